[rtl/alpe_pkg.sv]
package alpe_pkg;

  // Register indexes on the configuration port
  localparam int unsigned CFG_IDX_BITS = 3;
  localparam logic [CFG_IDX_BITS-1:0] REG_ONE_HIGH  = 3'd0;
  localparam logic [CFG_IDX_BITS-1:0] REG_ONE_LOW   = 3'd1;
  localparam logic [CFG_IDX_BITS-1:0] REG_ZERO_HIGH = 3'd2;
  localparam logic [CFG_IDX_BITS-1:0] REG_ZERO_LOW  = 3'd3;
  localparam logic [CFG_IDX_BITS-1:0] REG_LATCH_GAP = 3'd4;
  localparam logic [CFG_IDX_BITS-1:0] REG_PAD_EN    = 3'd5;

  // Reset values, truncated to the duration width where used
  localparam int unsigned RST_ONE_HIGH  = 65;
  localparam int unsigned RST_ONE_LOW   = 15;
  localparam int unsigned RST_ZERO_HIGH = 15;
  localparam int unsigned RST_ZERO_LOW  = 65;
  localparam int unsigned RST_LATCH_GAP = 2353;

  localparam int unsigned COLOR_BITS = 8;
  localparam int unsigned WORD_BITS  = 32;
  localparam int unsigned PIX_BITS   = 24;
  localparam int unsigned POS_BITS   = 6;

  // One classified pixel waiting for the back end
  typedef struct packed {
    logic [WORD_BITS-1:0] word;  // green, red, blue, pad byte; MSB goes first
    logic                 pad;   // send all 32 bits
    logic                 latch; // append the frame reset gap
  } entry_t;

endpackage

[rtl/alpe_front.sv]
module alpe_front #(
  parameter int unsigned DW = 16
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [alpe_pkg::CFG_IDX_BITS-1:0]   cfg_index,
  input  logic [DW-1:0]                       cfg_wdata,
  input  logic [alpe_pkg::COLOR_BITS-1:0]     green,
  input  logic [alpe_pkg::COLOR_BITS-1:0]     red,
  input  logic [alpe_pkg::COLOR_BITS-1:0]     blue,
  input  logic                                frame_end,
  output alpe_pkg::entry_t                    entry,
  output logic [DW-1:0]                       one_high,
  output logic [DW-1:0]                       one_low,
  output logic [DW-1:0]                       zero_high,
  output logic [DW-1:0]                       zero_low,
  output logic [DW-1:0]                       latch_gap
);

  logic [DW-1:0] one_high_r, one_low_r, zero_high_r, zero_low_r, latch_gap_r;
  logic          pad_en_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      one_high_r  <= DW'(alpe_pkg::RST_ONE_HIGH);
      one_low_r   <= DW'(alpe_pkg::RST_ONE_LOW);
      zero_high_r <= DW'(alpe_pkg::RST_ZERO_HIGH);
      zero_low_r  <= DW'(alpe_pkg::RST_ZERO_LOW);
      latch_gap_r <= DW'(alpe_pkg::RST_LATCH_GAP);
      pad_en_r    <= 1'b1;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        alpe_pkg::REG_ONE_HIGH:  one_high_r  <= cfg_wdata;
        alpe_pkg::REG_ONE_LOW:   one_low_r   <= cfg_wdata;
        alpe_pkg::REG_ZERO_HIGH: zero_high_r <= cfg_wdata;
        alpe_pkg::REG_ZERO_LOW:  zero_low_r  <= cfg_wdata;
        alpe_pkg::REG_LATCH_GAP: latch_gap_r <= cfg_wdata;
        alpe_pkg::REG_PAD_EN:    pad_en_r    <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  // Classify: pack the bit stream and note its length and the frame end
  always_comb begin
    entry.word  = {green, red, blue, {alpe_pkg::COLOR_BITS{1'b0}}};
    entry.pad   = pad_en_r;
    entry.latch = frame_end;
  end

  assign one_high  = one_high_r;
  assign one_low   = one_low_r;
  assign zero_high = zero_high_r;
  assign zero_low  = zero_low_r;
  assign latch_gap = latch_gap_r;

endmodule

[rtl/alpe_queue.sv]
module alpe_queue (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  alpe_pkg::entry_t push_entry,
  output logic             full,
  input  logic             pop,
  output alpe_pkg::entry_t head,
  output logic             head_valid
);

  alpe_pkg::entry_t mem_r [2];
  logic             wr_ptr_r, rd_ptr_r;
  logic [1:0]       cnt_r;
  logic             do_push, do_pop;

  assign full       = (cnt_r == 2'd2);
  assign head_valid = (cnt_r != 2'd0);
  assign do_push    = push && !full;
  assign do_pop     = pop && head_valid;
  assign head       = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      if (do_push) wr_ptr_r <= ~wr_ptr_r;
      if (do_pop)  rd_ptr_r <= ~rd_ptr_r;
      cnt_r <= cnt_r + {1'b0, do_push} - {1'b0, do_pop};
    end
  end

endmodule

[rtl/alpe_back.sv]
module alpe_back #(
  parameter int unsigned DW = 16
) (
  input  logic             clk,
  input  logic             rst_n,
  input  alpe_pkg::entry_t head,
  input  logic             head_valid,
  output logic             head_pop,
  input  logic [DW-1:0]    one_high,
  input  logic [DW-1:0]    one_low,
  input  logic [DW-1:0]    zero_high,
  input  logic [DW-1:0]    zero_low,
  input  logic [DW-1:0]    latch_gap,
  output logic             out_empty,
  input  logic             out_pop,
  output logic [DW-1:0]    out_high_cycles,
  output logic [DW-1:0]    out_low_cycles,
  output logic             out_is_latch,
  output logic             out_run_end
);

  localparam logic [alpe_pkg::POS_BITS-1:0] N_FULL =
    alpe_pkg::POS_BITS'(alpe_pkg::WORD_BITS);
  localparam logic [alpe_pkg::POS_BITS-1:0] N_PIX =
    alpe_pkg::POS_BITS'(alpe_pkg::PIX_BITS);

  logic [alpe_pkg::POS_BITS-1:0] pos_r, nbits;
  logic                          out_valid_r;
  logic [DW-1:0]                 high_r, low_r;
  logic                          latch_r, run_end_r;
  logic                          emit, latch_pos, last_bit, at_end, bit_val;

  assign nbits     = head.pad ? N_FULL : N_PIX;
  assign latch_pos = (pos_r == nbits);
  assign last_bit  = (pos_r == nbits - 1'b1);
  assign at_end    = latch_pos || (last_bit && !head.latch);
  // Bit 31-pos of the word; only read while pos is below 32
  assign bit_val   = head.word[~pos_r[4:0]];
  assign emit      = head_valid && (!out_valid_r || out_pop);
  assign head_pop  = emit && at_end;

  always_ff @(posedge clk) begin
    if (emit) begin
      if (latch_pos) begin
        high_r  <= '0;
        low_r   <= latch_gap;
        latch_r <= 1'b1;
      end else begin
        high_r  <= bit_val ? one_high : zero_high;
        low_r   <= bit_val ? one_low : zero_low;
        latch_r <= 1'b0;
      end
      run_end_r <= at_end;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      pos_r       <= '0;
    end else begin
      if (emit) begin
        out_valid_r <= 1'b1;
        pos_r       <= at_end ? '0 : pos_r + 1'b1;
      end else if (out_pop) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_empty       = !out_valid_r;
  assign out_high_cycles = high_r;
  assign out_low_cycles  = low_r;
  assign out_is_latch    = latch_r;
  assign out_run_end     = run_end_r;

`ifndef SYNTHESIS
  a_pos_range: assert property (@(posedge clk) disable iff (!rst_n)
    pos_r <= N_FULL) else $error("bit position past end of word");

  a_latch_ends_run: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && latch_r |-> run_end_r && (high_r == '0))
    else $error("latch descriptor not marked as run end");

  a_pop_restarts: assert property (@(posedge clk) disable iff (!rst_n)
    head_pop |=> pos_r == '0) else $error("position not cleared after pixel");

  a_pop_only_on_emit: assert property (@(posedge clk) disable iff (!rst_n)
    head_pop |-> emit && head_valid) else $error("queue popped without emit");
`endif

endmodule

[rtl/addressable_led_pulse_encoder.sv]
// Pulse descriptor encoder for single-wire addressable LED strings. Push one
// pixel word (green, red, blue, frame_end); the block returns one descriptor
// word per color bit, green then red then blue, MSB first, each carrying the
// high and low durations for a one or a zero bit. With pad_byte_enable set,
// eight zero-bit descriptors follow blue. A pixel marked frame_end ends with
// a latch descriptor (high 0, low = latch gap, is_latch set). run_end marks
// the last descriptor of each pixel. A pixel has 24, 25, 32 or 33
// descriptors: the back-end sequencer emits one per cycle into the output
// register, so the descriptor count sets the rate. The front end takes a new
// pixel in any cycle that its 2-deep queue has room, and the output stage
// keeps loading as long as pop drains it. Write configuration only while the
// block is idle; indexes 6 and 7 are ignored. No clearing pass after reset.
module addressable_led_pulse_encoder #(
  parameter int unsigned DURATION_BITS = 16
) (
  input  logic                              clk,
  input  logic                              rst_n,
  // configuration write channel
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [alpe_pkg::CFG_IDX_BITS-1:0] cfg_index,
  input  logic [DURATION_BITS-1:0]          cfg_wdata,
  // pixel input
  input  logic                              in_push,
  output logic                              in_full,
  input  logic [alpe_pkg::COLOR_BITS-1:0]   in_green,
  input  logic [alpe_pkg::COLOR_BITS-1:0]   in_red,
  input  logic [alpe_pkg::COLOR_BITS-1:0]   in_blue,
  input  logic                              in_frame_end,
  // descriptor output
  output logic                              out_empty,
  input  logic                              out_pop,
  output logic [DURATION_BITS-1:0]          out_high_cycles,
  output logic [DURATION_BITS-1:0]          out_low_cycles,
  output logic                              out_is_latch,
  output logic                              out_run_end
);

  alpe_pkg::entry_t           front_entry, head;
  logic                       head_valid, head_pop;
  logic [DURATION_BITS-1:0]   one_high, one_low, zero_high, zero_low, latch_gap;

  // Front: hold config, classify each pixel
  alpe_front #(.DW(DURATION_BITS)) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .green     (in_green),
    .red       (in_red),
    .blue      (in_blue),
    .frame_end (in_frame_end),
    .entry     (front_entry),
    .one_high  (one_high),
    .one_low   (one_low),
    .zero_high (zero_high),
    .zero_low  (zero_low),
    .latch_gap (latch_gap)
  );

  // Decouple: two pixels may wait while the back end works
  alpe_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (in_push),
    .push_entry (front_entry),
    .full       (in_full),
    .pop        (head_pop),
    .head       (head),
    .head_valid (head_valid)
  );

  // Back: step through the bits, one descriptor per cycle while pop drains the output
  alpe_back #(.DW(DURATION_BITS)) u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .head            (head),
    .head_valid      (head_valid),
    .head_pop        (head_pop),
    .one_high        (one_high),
    .one_low         (one_low),
    .zero_high       (zero_high),
    .zero_low        (zero_low),
    .latch_gap       (latch_gap),
    .out_empty       (out_empty),
    .out_pop         (out_pop),
    .out_high_cycles (out_high_cycles),
    .out_low_cycles  (out_low_cycles),
    .out_is_latch    (out_is_latch),
    .out_run_end     (out_run_end)
  );

endmodule

[dv/tb.sv]
module tb;

  localparam int unsigned DB = 16;
  // Indexes past the last register; writes to them must leave every register alone
  localparam logic [alpe_pkg::CFG_IDX_BITS-1:0] REG_SPARE_6 = 3'd6;
  localparam logic [alpe_pkg::CFG_IDX_BITS-1:0] REG_SPARE_7 = 3'd7;
  // Worst case is roughly 360 pixels x 33 descriptors, each behind the longest pop stall;
  // take that several times over
  localparam int unsigned CYCLE_LIMIT = 2_000_000;
  localparam int unsigned PHASE_ITEMS = 55;

  typedef struct {
    logic [alpe_pkg::COLOR_BITS-1:0] green, red, blue;
    logic                            frame_end;
  } pixel_t;

  typedef struct {
    logic [DB-1:0] high_cycles;
    logic [DB-1:0] low_cycles;
    logic          is_latch;
    logic          run_end;
  } pulse_t;

  logic                              clk = 1'b0;
  logic                              rst_n = 1'b0;
  logic                              cfg_valid = 1'b0;
  logic                              cfg_ready;
  logic [alpe_pkg::CFG_IDX_BITS-1:0] cfg_index = '0;
  logic [DB-1:0]                     cfg_wdata = '0;
  logic                              in_push = 1'b0;
  logic                              in_full;
  logic [alpe_pkg::COLOR_BITS-1:0]   in_green = '0;
  logic [alpe_pkg::COLOR_BITS-1:0]   in_red = '0;
  logic [alpe_pkg::COLOR_BITS-1:0]   in_blue = '0;
  logic                              in_frame_end = 1'b0;
  logic                              out_empty;
  logic                              out_pop = 1'b0;
  logic [DB-1:0]                     out_high_cycles;
  logic [DB-1:0]                     out_low_cycles;
  logic                              out_is_latch;
  logic                              out_run_end;

  // Local copy of the timing registers, starting at their reset values
  logic [DB-1:0] t_one_hi  = DB'(alpe_pkg::RST_ONE_HIGH);
  logic [DB-1:0] t_one_lo  = DB'(alpe_pkg::RST_ONE_LOW);
  logic [DB-1:0] t_zero_hi = DB'(alpe_pkg::RST_ZERO_HIGH);
  logic [DB-1:0] t_zero_lo = DB'(alpe_pkg::RST_ZERO_LOW);
  logic [DB-1:0] t_latch   = DB'(alpe_pkg::RST_LATCH_GAP);
  logic          t_pad     = 1'b1;

  pixel_t      pix_pending[$];     // pixels waiting for the driver
  pixel_t      pix_on_bus;         // pixel currently presented on in_*
  pulse_t      pulse_expect_q[$];  // descriptors predicted, oldest first
  int unsigned err_count = 0;
  int unsigned cyc_count = 0;
  int unsigned push_hold = 0;
  int unsigned pop_hold = 0;
  bit          push_calm = 1'b0;
  bit          pop_calm = 1'b0;

  addressable_led_pulse_encoder #(.DURATION_BITS(DB)) u_dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_wdata      (cfg_wdata),
    .in_push        (in_push),
    .in_full        (in_full),
    .in_green       (in_green),
    .in_red         (in_red),
    .in_blue        (in_blue),
    .in_frame_end   (in_frame_end),
    .out_empty      (out_empty),
    .out_pop        (out_pop),
    .out_high_cycles(out_high_cycles),
    .out_low_cycles (out_low_cycles),
    .out_is_latch   (out_is_latch),
    .out_run_end    (out_run_end)
  );

  always #5 clk = ~clk;

  // Hard stop in case the block hangs
  always @(posedge clk) begin
    cyc_count++;
    if (cyc_count > CYCLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // Idle length for either side: mostly none, some short, a few long.
  // A calm side never idles, which gives back-to-back stretches.
  function automatic int unsigned pick_wait(bit calm);
    int unsigned r;
    r = $urandom_range(0, 99);
    if (calm || r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 8);
    return $urandom_range(12, 30);
  endfunction

  // Expand one pixel into its descriptor train: 24 color bits green-red-blue,
  // MSB first, then eight zero bits when padding is on, then the latch gap
  // for the last pixel of a frame. run_end flags the final descriptor.
  function automatic void encode_pixel(pixel_t p);
    logic [3*alpe_pkg::COLOR_BITS-1:0] grb;
    int unsigned                       n_color;
    int unsigned                       n_pad;
    int unsigned                       n_total;
    pulse_t                            d;
    grb     = {p.green, p.red, p.blue};
    n_color = 3 * alpe_pkg::COLOR_BITS;
    n_pad   = t_pad ? alpe_pkg::COLOR_BITS : 0;
    n_total = n_color + n_pad + (p.frame_end ? 1 : 0);
    for (int k = 0; k < n_total; k++) begin
      if (k < n_color && grb[n_color-1-k]) begin
        d.high_cycles = t_one_hi;
        d.low_cycles  = t_one_lo;
        d.is_latch    = 1'b0;
      end else if (k < n_color + n_pad) begin
        d.high_cycles = t_zero_hi;
        d.low_cycles  = t_zero_lo;
        d.is_latch    = 1'b0;
      end else begin
        d.high_cycles = '0;
        d.low_cycles  = t_latch;
        d.is_latch    = 1'b1;
      end
      d.run_end = (k == n_total - 1);
      pulse_expect_q.push_back(d);
    end
  endfunction

  function automatic void check_field(string name, logic [DB-1:0] want, logic [DB-1:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
      err_count++;
    end
  endfunction

  function automatic void check_pulse();
    pulse_t want;
    if (pulse_expect_q.size() == 0) begin
      $display("%0t: unexpected descriptor, expected none, got high=%0d low=%0d latch=%0b end=%0b",
               $time, out_high_cycles, out_low_cycles, out_is_latch, out_run_end);
      err_count++;
      return;
    end
    want = pulse_expect_q.pop_front();
    check_field("high_cycles", want.high_cycles, out_high_cycles);
    check_field("low_cycles", want.low_cycles, out_low_cycles);
    check_field("is_latch", DB'(want.is_latch), DB'(out_is_latch));
    check_field("run_end", DB'(want.run_end), DB'(out_run_end));
  endfunction

  // Pixel driver: present the next pending word, hold it while full is high,
  // then idle for a random gap before the next one. Predict on acceptance.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_push <= 1'b0;
    end else begin
      if ($urandom_range(0, 199) == 0) push_calm = !push_calm;
      if (in_push && !in_full) encode_pixel(pix_on_bus);
      // A stalled word stays on the bus untouched
      if (!in_push || !in_full) begin
        if (push_hold != 0) begin
          push_hold--;
          in_push <= 1'b0;
        end else if (pix_pending.size() != 0) begin
          pix_on_bus = pix_pending.pop_front();
          in_green     <= pix_on_bus.green;
          in_red       <= pix_on_bus.red;
          in_blue      <= pix_on_bus.blue;
          in_frame_end <= pix_on_bus.frame_end;
          in_push      <= 1'b1;
          push_hold = pick_wait(push_calm);
        end else begin
          in_push <= 1'b0;
        end
      end
    end
  end

  // Descriptor monitor: check each popped word against the oldest prediction,
  // then stall pop for a random stretch.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_pop <= 1'b0;
    end else begin
      if ($urandom_range(0, 199) == 0) pop_calm = !pop_calm;
      if (out_pop && !out_empty) begin
        check_pulse();
        pop_hold = pick_wait(pop_calm);
      end else if (pop_hold != 0) begin
        pop_hold--;
      end
      out_pop <= (pop_hold == 0);
    end
  end

  // Write one register and mirror the write into the local copy: durations
  // keep the low DB bits, the pad enable keeps bit 0, spare indexes drop out.
  task automatic write_reg(input logic [alpe_pkg::CFG_IDX_BITS-1:0] idx,
                           input logic [DB-1:0] val);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (idx)
      alpe_pkg::REG_ONE_HIGH:  t_one_hi  = val;
      alpe_pkg::REG_ONE_LOW:   t_one_lo  = val;
      alpe_pkg::REG_ZERO_HIGH: t_zero_hi = val;
      alpe_pkg::REG_ZERO_LOW:  t_zero_lo = val;
      alpe_pkg::REG_LATCH_GAP: t_latch   = val;
      alpe_pkg::REG_PAD_EN:    t_pad     = val[0];
      default: ;
    endcase
  endtask

  task automatic add_pixel(input logic [7:0] g, input logic [7:0] r, input logic [7:0] b,
                           input logic fe);
    pixel_t p;
    p.green     = g;
    p.red       = r;
    p.blue      = b;
    p.frame_end = fe;
    pix_pending.push_back(p);
  endtask

  // Bias color bytes toward all-zero and all-one words
  function automatic logic [7:0] rand_byte();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 12) return 8'h00;
    if (r < 24) return 8'hFF;
    return 8'($urandom_range(0, 255));
  endfunction

  // Mostly whole frames (several pixels, frame_end on the last), with some
  // stray pixels carrying a random frame_end mixed in
  task automatic queue_random(input int unsigned n);
    int unsigned cnt;
    int unsigned len;
    cnt = 0;
    while (cnt < n) begin
      if ($urandom_range(0, 9) < 7) begin
        len = $urandom_range(1, 6);
        for (int i = 0; i < len; i++)
          add_pixel(rand_byte(), rand_byte(), rand_byte(), i == len - 1);
        cnt += len;
      end else begin
        add_pixel(rand_byte(), rand_byte(), rand_byte(), 1'($urandom_range(0, 1)));
        cnt++;
      end
    end
  endtask

  // Block until everything queued has gone in and every descriptor came out,
  // then let the pipeline settle before touching registers
  task automatic wait_drained();
    while (pix_pending.size() != 0 || in_push || pulse_expect_q.size() != 0)
      @(negedge clk);
    repeat (6) @(posedge clk);
  endtask

  function automatic logic [DB-1:0] rand_dur();
    int unsigned r;
    r = $urandom_range(0, 9);
    if (r == 0) return '0;
    if (r == 1) return '1;
    if (r == 2) return DB'(1);
    return DB'($urandom_range(0, 65535));
  endfunction

  initial begin
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    // Reset timings: solid colors, single-channel words, alternating bits,
    // with and without the latch gap
    add_pixel(8'h00, 8'h00, 8'h00, 1'b0);
    add_pixel(8'hFF, 8'hFF, 8'hFF, 1'b0);
    add_pixel(8'hFF, 8'h00, 8'h00, 1'b0);
    add_pixel(8'h00, 8'hFF, 8'h00, 1'b0);
    add_pixel(8'h00, 8'h00, 8'hFF, 1'b1);
    add_pixel(8'hAA, 8'h55, 8'hAA, 1'b0);
    add_pixel(8'h55, 8'hAA, 8'h55, 1'b1);
    add_pixel(8'h80, 8'h01, 8'h80, 1'b1);
    add_pixel(8'hFF, 8'hFF, 8'hFF, 1'b1);
    queue_random(PHASE_ITEMS);
    wait_drained();

    // Extremes: max/min durations, a zero high time, a zero latch gap.
    // Pad off through a wide value whose bit 0 is clear; spare indexes ignored.
    write_reg(alpe_pkg::REG_ONE_HIGH, 16'hFFFF);
    write_reg(alpe_pkg::REG_ONE_LOW, 16'h0001);
    write_reg(alpe_pkg::REG_ZERO_HIGH, 16'h0000);
    write_reg(alpe_pkg::REG_ZERO_LOW, 16'hFFFF);
    write_reg(alpe_pkg::REG_LATCH_GAP, 16'h0000);
    write_reg(alpe_pkg::REG_PAD_EN, 16'hFFFE);
    write_reg(REG_SPARE_6, 16'h1234);
    write_reg(REG_SPARE_7, 16'hFFFF);
    add_pixel(8'hFF, 8'h00, 8'hFF, 1'b1);
    add_pixel(8'h00, 8'h00, 8'h00, 1'b1);
    add_pixel(8'h01, 8'h80, 8'h7F, 1'b0);
    add_pixel(8'hFE, 8'h7F, 8'h01, 1'b1);
    queue_random(PHASE_ITEMS);
    wait_drained();

    // Minimum and maximum durations mixed, widest latch gap, pad back on via bit 0
    write_reg(alpe_pkg::REG_ONE_HIGH, 16'h0001);
    write_reg(alpe_pkg::REG_ONE_LOW, 16'hFFFF);
    write_reg(alpe_pkg::REG_ZERO_HIGH, 16'hFFFF);
    write_reg(alpe_pkg::REG_ZERO_LOW, 16'h0001);
    write_reg(alpe_pkg::REG_LATCH_GAP, 16'hFFFF);
    write_reg(alpe_pkg::REG_PAD_EN, 16'h0003);
    write_reg(REG_SPARE_6, 16'h0000);
    add_pixel(8'h00, 8'hFF, 8'h00, 1'b1);
    add_pixel(8'h5A, 8'hA5, 8'hC3, 1'b0);
    queue_random(PHASE_ITEMS);
    wait_drained();

    // Random settings, including zeros and wide pad values
    repeat (3) begin
      write_reg(alpe_pkg::REG_ONE_HIGH, rand_dur());
      write_reg(alpe_pkg::REG_ONE_LOW, rand_dur());
      write_reg(alpe_pkg::REG_ZERO_HIGH, rand_dur());
      write_reg(alpe_pkg::REG_ZERO_LOW, rand_dur());
      write_reg(alpe_pkg::REG_LATCH_GAP, rand_dur());
      write_reg(alpe_pkg::REG_PAD_EN, DB'($urandom_range(0, 65535)));
      queue_random(PHASE_ITEMS);
      wait_drained();
    end

    // Let any stray descriptor show up before the verdict
    repeat (40) @(posedge clk);
    if (err_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
